>>> hw/rtl/sewm_pkg.sv
// shared widths, sequencer states and accumulate targets for the shower moments block
package sewm_pkg;

  localparam int ENERGY_W = 16;
  localparam int POS_W    = 16;
  localparam int TIME_W   = 16;
  localparam int TOTAL_W  = 22;
  localparam int USED_W   = 7;
  localparam int WIDTH_W  = 34;
  localparam int MUL_W    = 32;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int CEN_W    = POS_W + 1;
  localparam int MSQ_W    = 2 * POS_W - 1;
  localparam int ROOT_W   = 31;
  localparam int SUMSQ_W  = 2 * ROOT_W;
  localparam int STEP_W   = 4;
  localparam logic [STEP_W-1:0] MAC_LAST_STEP = 4'd11;
  localparam int DIV_N    = 8;

  typedef enum logic [13:0] {
    ST_IDLE      = 14'b00000000000001,
    ST_MAC       = 14'b00000000000010,
    ST_FIN       = 14'b00000000000100,
    ST_DIV_GO    = 14'b00000000001000,
    ST_DIV_WAIT  = 14'b00000000010000,
    ST_VAR_MUL   = 14'b00000000100000,
    ST_VAR_SUB   = 14'b00000001000000,
    ST_SEL       = 14'b00000010000000,
    ST_SQX       = 14'b00000100000000,
    ST_SQY       = 14'b00001000000000,
    ST_SQADD     = 14'b00010000000000,
    ST_ROOT_GO   = 14'b00100000000000,
    ST_ROOT_WAIT = 14'b01000000000000,
    ST_OUT       = 14'b10000000000000
  } state_e;

  typedef enum logic [3:0] {
    TGT_NONE,
    TGT_POS_X,
    TGT_POS_Y,
    TGT_POS_Z,
    TGT_SQ_X,
    TGT_SQ_Y,
    TGT_SQ_Z,
    TGT_TIME_1,
    TGT_TIME_2
  } target_e;

  // start of a serial arithmetic unit, and its busy and done
  typedef struct packed {
    logic start;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> hw/rtl/shower_energy_weighted_moments.sv
// top level: energy-weighted moments of one calorimeter shower, one bar per transaction
//
// A bar is taken when start is high and busy is low; busy then stays high while the bar
// is folded into the running sums. One shared 32x32 multiplier and one shared adder do
// eleven products per bar. On the bar marked last the block then runs eight serial
// divisions through one restoring divider of DIV_W = 46 + clog2(MAX_BARS + 1) bits, 53
// at the default, three square/subtract pairs for the variances, and, when both x and y
// variances are nonzero and z is flat, two squarings and a 31-bit square root. The
// result is shown for exactly one cycle with result_valid_o high; there is no way to hold
// it, so the receiver must take it in that cycle. A zero-energy shower skips the
// divisions and reports zeros with zero_energy_o set. Bars that arrive after MAX_BARS
// are ignored and flagged; the sums clear after each result.
module shower_energy_weighted_moments #(
  parameter int MAX_BARS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [sewm_pkg::ENERGY_W-1:0]       bar_energy_i,
  input  logic signed [sewm_pkg::POS_W-1:0]   bar_x_i,
  input  logic signed [sewm_pkg::POS_W-1:0]   bar_y_i,
  input  logic signed [sewm_pkg::POS_W-1:0]   bar_z_i,
  input  logic [sewm_pkg::TIME_W-1:0]         bar_time_first_i,
  input  logic [sewm_pkg::TIME_W-1:0]         bar_time_second_i,
  input  logic                                last_bar_i,
  output logic                                result_valid_o,
  output logic [sewm_pkg::TOTAL_W-1:0]        total_energy_o,
  output logic signed [sewm_pkg::POS_W-1:0]   centroid_x_o,
  output logic signed [sewm_pkg::POS_W-1:0]   centroid_y_o,
  output logic signed [sewm_pkg::POS_W-1:0]   centroid_z_o,
  output logic [sewm_pkg::TIME_W-1:0]         mean_time_first_o,
  output logic [sewm_pkg::TIME_W-1:0]         mean_time_second_o,
  output logic [sewm_pkg::WIDTH_W-1:0]        shower_width_o,
  output logic [sewm_pkg::USED_W-1:0]         bars_used_o,
  output logic                                zero_energy_o,
  output logic                                bars_dropped_o
);
  import sewm_pkg::*;

  // sum widths grow with the bar count
  localparam int CNT_W = $clog2(MAX_BARS + 1);
  localparam int ES_W  = ENERGY_W + CNT_W;
  localparam int PS_W  = 2 * POS_W + 1 + CNT_W;
  localparam int SS_W  = 3 * POS_W - 2 + CNT_W;
  localparam int TS_W  = ENERGY_W + TIME_W + CNT_W;
  localparam int DIV_W = SS_W;

  state_e state_q, state_d;

  // latched bar
  logic [ENERGY_W-1:0]     e_q;
  logic signed [POS_W-1:0] x_q, y_q, z_q;
  logic [TIME_W-1:0]       t1_q, t2_q;
  logic                    last_q;

  // running sums
  logic [ES_W-1:0]        energy_sum_q, energy_sum_d;
  logic signed [PS_W-1:0] pos_sum_q [3];
  logic signed [PS_W-1:0] pos_sum_d [3];
  logic [SS_W-1:0]        sq_sum_q [3];
  logic [SS_W-1:0]        sq_sum_d [3];
  logic [TS_W-1:0]        t_sum_q [2];
  logic [TS_W-1:0]        t_sum_d [2];
  logic [CNT_W-1:0]       bar_count_q, bar_count_d;
  logic                   overflow_q, overflow_d;

  // sequencer
  logic [STEP_W-1:0] step_q, step_d;
  target_e           tag_q, tag_d;
  logic [2:0]        div_idx_q, div_idx_d;
  logic [1:0]        var_idx_q, var_idx_d;

  // shared multiplier and adder
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [PROD_W-1:0] acc_in, acc_sum;

  // finishing results
  logic signed [CEN_W-1:0] cen_q [3];
  logic signed [CEN_W-1:0] cen_d [3];
  logic [MSQ_W-1:0]        msq_q [3];
  logic [MSQ_W-1:0]        msq_d [3];
  logic [MSQ_W-1:0]        var_q [3];
  logic [MSQ_W-1:0]        var_d [3];
  logic [TIME_W-1:0]       mt_q [2];
  logic [TIME_W-1:0]       mt_d [2];
  logic [SUMSQ_W-1:0]      sumsq_q, sumsq_d;
  logic [WIDTH_W-1:0]      width_q, width_d;

  // serial units
  unit_ctrl_t       div_ctrl, root_ctrl;
  unit_stat_t       div_stat, root_stat;
  logic [DIV_W-1:0] dividend;
  logic [DIV_W-1:0] quotient;
  logic [ROOT_W-1:0] root;
  logic [PS_W-1:0]  pos_mag;
  logic             pos_neg;
  logic [CEN_W-1:0] cen_mag;

  logic bar_taken;
  logic room;
  logic zero_e;

  assign room      = (32'(bar_count_q) < 32'(MAX_BARS));
  assign bar_taken = start && (state_q == ST_IDLE);
  assign zero_e    = (energy_sum_q == '0);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    tag_d = TGT_NONE;
    unique case (state_q)
      ST_MAC: begin
        unique case (step_q)
          4'd0:  begin mul_a = MUL_W'(e_q); mul_b = MUL_W'(x_q); tag_d = TGT_POS_X; end
          4'd1:  begin mul_a = MUL_W'(x_q); mul_b = MUL_W'(x_q); end
          4'd2:  begin mul_a = prod_q[MUL_W-1:0]; mul_b = MUL_W'(e_q); tag_d = TGT_SQ_X; end
          4'd3:  begin mul_a = MUL_W'(e_q); mul_b = MUL_W'(y_q); tag_d = TGT_POS_Y; end
          4'd4:  begin mul_a = MUL_W'(y_q); mul_b = MUL_W'(y_q); end
          4'd5:  begin mul_a = prod_q[MUL_W-1:0]; mul_b = MUL_W'(e_q); tag_d = TGT_SQ_Y; end
          4'd6:  begin mul_a = MUL_W'(e_q); mul_b = MUL_W'(z_q); tag_d = TGT_POS_Z; end
          4'd7:  begin mul_a = MUL_W'(z_q); mul_b = MUL_W'(z_q); end
          4'd8:  begin mul_a = prod_q[MUL_W-1:0]; mul_b = MUL_W'(e_q); tag_d = TGT_SQ_Z; end
          4'd9:  begin mul_a = MUL_W'(e_q); mul_b = MUL_W'(t1_q); tag_d = TGT_TIME_1; end
          4'd10: begin mul_a = MUL_W'(e_q); mul_b = MUL_W'(t2_q); tag_d = TGT_TIME_2; end
          default: ;
        endcase
      end
      ST_VAR_MUL: begin
        mul_a = MUL_W'(cen_q[var_idx_q]);
        mul_b = MUL_W'(cen_q[var_idx_q]);
      end
      ST_SQX: begin
        mul_a = MUL_W'(var_q[0]);
        mul_b = MUL_W'(var_q[0]);
      end
      ST_SQY: begin
        mul_a = MUL_W'(var_q[1]);
        mul_b = MUL_W'(var_q[1]);
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // shared accumulate adder, fed by the product of the previous step
  always_comb begin
    unique case (tag_q)
      TGT_POS_X:  acc_in = PROD_W'(pos_sum_q[0]);
      TGT_POS_Y:  acc_in = PROD_W'(pos_sum_q[1]);
      TGT_POS_Z:  acc_in = PROD_W'(pos_sum_q[2]);
      TGT_SQ_X:   acc_in = PROD_W'(sq_sum_q[0]);
      TGT_SQ_Y:   acc_in = PROD_W'(sq_sum_q[1]);
      TGT_SQ_Z:   acc_in = PROD_W'(sq_sum_q[2]);
      TGT_TIME_1: acc_in = PROD_W'(t_sum_q[0]);
      TGT_TIME_2: acc_in = PROD_W'(t_sum_q[1]);
      default:    acc_in = '0;
    endcase
    acc_sum = acc_in + prod_q;
  end

  // dividend selection: position sums go in as magnitudes
  always_comb begin
    pos_neg  = 1'b0;
    pos_mag  = '0;
    dividend = '0;
    unique case (div_idx_q)
      3'd0, 3'd1, 3'd2: begin
        pos_neg  = pos_sum_q[div_idx_q[1:0]][PS_W-1];
        pos_mag  = pos_neg ? PS_W'(-pos_sum_q[div_idx_q[1:0]])
                           : PS_W'(pos_sum_q[div_idx_q[1:0]]);
        dividend = DIV_W'(pos_mag);
      end
      3'd3: dividend = DIV_W'(sq_sum_q[0]);
      3'd4: dividend = DIV_W'(sq_sum_q[1]);
      3'd5: dividend = DIV_W'(sq_sum_q[2]);
      3'd6: dividend = DIV_W'(t_sum_q[0]);
      default: dividend = DIV_W'(t_sum_q[1]);
    endcase
    cen_mag = quotient[CEN_W-1:0];
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    div_idx_d    = div_idx_q;
    var_idx_d    = var_idx_q;
    energy_sum_d = energy_sum_q;
    pos_sum_d    = pos_sum_q;
    sq_sum_d     = sq_sum_q;
    t_sum_d      = t_sum_q;
    bar_count_d  = bar_count_q;
    overflow_d   = overflow_q;
    cen_d        = cen_q;
    msq_d        = msq_q;
    var_d        = var_q;
    mt_d         = mt_q;
    sumsq_d      = sumsq_q;
    width_d      = width_q;
    div_ctrl.start  = 1'b0;
    root_ctrl.start = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (room) begin
            energy_sum_d = energy_sum_q + ES_W'(bar_energy_i);
            bar_count_d  = bar_count_q + 1'b1;
            step_d       = '0;
            state_d      = ST_MAC;
          end else begin
            // bar beyond capacity: ignored, but a last marker still closes the shower
            overflow_d = 1'b1;
            if (last_bar_i) begin
              state_d = ST_FIN;
            end
          end
        end
      end

      ST_MAC: begin
        unique case (tag_q)
          TGT_POS_X:  pos_sum_d[0] = acc_sum[PS_W-1:0];
          TGT_POS_Y:  pos_sum_d[1] = acc_sum[PS_W-1:0];
          TGT_POS_Z:  pos_sum_d[2] = acc_sum[PS_W-1:0];
          TGT_SQ_X:   sq_sum_d[0]  = acc_sum[SS_W-1:0];
          TGT_SQ_Y:   sq_sum_d[1]  = acc_sum[SS_W-1:0];
          TGT_SQ_Z:   sq_sum_d[2]  = acc_sum[SS_W-1:0];
          TGT_TIME_1: t_sum_d[0]   = acc_sum[TS_W-1:0];
          TGT_TIME_2: t_sum_d[1]   = acc_sum[TS_W-1:0];
          default: ;
        endcase
        step_d = step_q + 1'b1;
        if (step_q == MAC_LAST_STEP) begin
          state_d = last_q ? ST_FIN : ST_IDLE;
        end
      end

      ST_FIN: begin
        div_idx_d = '0;
        state_d   = zero_e ? ST_OUT : ST_DIV_GO;
      end

      ST_DIV_GO: begin
        div_ctrl.start = 1'b1;
        state_d        = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          unique case (div_idx_q)
            3'd0, 3'd1, 3'd2: cen_d[div_idx_q[1:0]] = pos_neg ? -cen_mag : cen_mag;
            3'd3: msq_d[0] = quotient[MSQ_W-1:0];
            3'd4: msq_d[1] = quotient[MSQ_W-1:0];
            3'd5: msq_d[2] = quotient[MSQ_W-1:0];
            3'd6: mt_d[0]  = quotient[TIME_W-1:0];
            default: mt_d[1] = quotient[TIME_W-1:0];
          endcase
          div_idx_d = div_idx_q + 1'b1;
          if (div_idx_q == 3'(DIV_N - 1)) begin
            var_idx_d = '0;
            state_d   = ST_VAR_MUL;
          end else begin
            state_d = ST_DIV_GO;
          end
        end
      end

      ST_VAR_MUL: state_d = ST_VAR_SUB;

      ST_VAR_SUB: begin
        // mean square minus squared mean, clamped at zero
        var_d[var_idx_q] = (msq_q[var_idx_q] > prod_q[MSQ_W-1:0])
                         ? msq_q[var_idx_q] - prod_q[MSQ_W-1:0] : '0;
        var_idx_d = var_idx_q + 1'b1;
        state_d   = (var_idx_q == 2'd2) ? ST_SEL : ST_VAR_MUL;
      end

      ST_SEL: begin
        priority if (var_q[2] != '0) begin
          width_d = WIDTH_W'(var_q[2]);
          state_d = ST_OUT;
        end else if (var_q[0] == '0) begin
          width_d = WIDTH_W'(var_q[1]);
          state_d = ST_OUT;
        end else if (var_q[1] == '0) begin
          width_d = WIDTH_W'(var_q[0]);
          state_d = ST_OUT;
        end else begin
          state_d = ST_SQX;
        end
      end

      ST_SQX: state_d = ST_SQY;

      ST_SQY: begin
        sumsq_d = prod_q[SUMSQ_W-1:0];
        state_d = ST_SQADD;
      end

      ST_SQADD: begin
        sumsq_d = sumsq_q + prod_q[SUMSQ_W-1:0];
        state_d = ST_ROOT_GO;
      end

      ST_ROOT_GO: begin
        root_ctrl.start = 1'b1;
        state_d         = ST_ROOT_WAIT;
      end

      ST_ROOT_WAIT: begin
        if (root_stat.done) begin
          width_d = WIDTH_W'(root);
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        energy_sum_d = '0;
        pos_sum_d    = '{default: '0};
        sq_sum_d     = '{default: '0};
        t_sum_d      = '{default: '0};
        bar_count_d  = '0;
        overflow_d   = 1'b0;
        state_d      = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      tag_q        <= TGT_NONE;
      div_idx_q    <= '0;
      var_idx_q    <= '0;
      energy_sum_q <= '0;
      pos_sum_q    <= '{default: '0};
      sq_sum_q     <= '{default: '0};
      t_sum_q      <= '{default: '0};
      bar_count_q  <= '0;
      overflow_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      tag_q        <= tag_d;
      div_idx_q    <= div_idx_d;
      var_idx_q    <= var_idx_d;
      energy_sum_q <= energy_sum_d;
      pos_sum_q    <= pos_sum_d;
      sq_sum_q     <= sq_sum_d;
      t_sum_q      <= t_sum_d;
      bar_count_q  <= bar_count_d;
      overflow_q   <= overflow_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (bar_taken) begin
      e_q    <= bar_energy_i;
      x_q    <= bar_x_i;
      y_q    <= bar_y_i;
      z_q    <= bar_z_i;
      t1_q   <= bar_time_first_i;
      t2_q   <= bar_time_second_i;
      last_q <= last_bar_i;
    end
    prod_q  <= prod_d;
    cen_q   <= cen_d;
    msq_q   <= msq_d;
    var_q   <= var_d;
    mt_q    <= mt_d;
    sumsq_q <= sumsq_d;
    width_q <= width_d;
  end

  sewm_divider #(
    .DVD_W (DIV_W),
    .DVS_W (ES_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (dividend),
    .divisor_i  (energy_sum_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  sewm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (root_ctrl),
    .radicand_i (sumsq_q),
    .stat_o     (root_stat),
    .root_o     (root)
  );

  // result transaction, one cycle wide
  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_OUT);
  assign zero_energy_o  = zero_e;
  assign bars_dropped_o = overflow_q;
  assign bars_used_o    = (32'(bar_count_q) > 32'd127) ? USED_W'(127)
                                                       : USED_W'(bar_count_q);
  assign total_energy_o = zero_e ? '0
                        : (32'(energy_sum_q) > 32'd4194303) ? TOTAL_W'(4194303)
                        : TOTAL_W'(energy_sum_q);
  assign centroid_x_o       = zero_e ? '0 : cen_q[0][POS_W-1:0];
  assign centroid_y_o       = zero_e ? '0 : cen_q[1][POS_W-1:0];
  assign centroid_z_o       = zero_e ? '0 : cen_q[2][POS_W-1:0];
  assign mean_time_first_o  = zero_e ? '0 : mt_q[0];
  assign mean_time_second_o = zero_e ? '0 : mt_q[1];
  assign shower_width_o     = zero_e ? '0 : width_q;

endmodule

>>> hw/rtl/sewm_divider.sv
// restoring unsigned divider, one quotient bit per cycle
module sewm_divider #(
  parameter int DVD_W = 53,
  parameter int DVS_W = 23
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sewm_pkg::unit_ctrl_t  ctrl_i,
  input  logic [DVD_W-1:0]      dividend_i,
  input  logic [DVS_W-1:0]      divisor_i,
  output sewm_pkg::unit_stat_t  stat_o,
  output logic [DVD_W-1:0]      quotient_o
);
  import sewm_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] work_q, work_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             qbit;

  always_comb begin
    trial = {rem_q, work_q[DVD_W-1]};
    diff  = trial - {1'b0, divisor_i};
    qbit  = (trial >= {1'b0, divisor_i});
    work_d = work_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      work_d = dividend_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DVD_W);
      run_d  = 1'b1;
    end else if (run_q) begin
      work_d = {work_q[DVD_W-2:0], qbit};
      rem_d  = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign quotient_o  = work_q;

endmodule

>>> hw/rtl/sewm_isqrt.sv
// digit-by-digit integer square root, one root bit per cycle
module sewm_isqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sewm_pkg::unit_ctrl_t            ctrl_i,
  input  logic [sewm_pkg::SUMSQ_W-1:0]    radicand_i,
  output sewm_pkg::unit_stat_t            stat_o,
  output logic [sewm_pkg::ROOT_W-1:0]     root_o
);
  import sewm_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [SUMSQ_W-1:0] rad_q, rad_d;
  logic [ROOT_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [ROOT_W+1:0]  rem_sh;
  logic [ROOT_W+1:0]  trial;
  logic [ROOT_W+1:0]  diff;
  logic               rbit;

  always_comb begin
    rem_sh = {rem_q, rad_q[SUMSQ_W-1:SUMSQ_W-2]};
    trial  = {root_q, 2'b01};
    diff   = rem_sh - trial;
    rbit   = (rem_sh >= trial);
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CNT_W'(ROOT_W);
      run_d  = 1'b1;
    end else if (run_q) begin
      rad_d  = {rad_q[SUMSQ_W-3:0], 2'b00};
      rem_d  = rbit ? diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
      root_d = {root_q[ROOT_W-2:0], rbit};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = run_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule
